FILE: design/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and codes for the first-fit heap allocator
// Request and result word layouts, request and status codes.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_FREE    = 2'd1;
    localparam logic [1:0] REQ_CALLOC  = 2'd2;
    localparam logic [1:0] REQ_REALLOC = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NULL    = 3'd1;
    localparam logic [2:0] ST_OOM     = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_OVF     = 3'd4;
    localparam logic [2:0] ST_UNKNOWN = 3'd5;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] request_size;
        logic [31:0] element_count;
        logic [31:0] user_address;
    } req_t;

    typedef struct packed {
        logic [31:0] result_address;
        logic [2:0]  status;
        logic [31:0] copy_source;
        logic [31:0] copy_bytes;
        logic [31:0] clear_bytes;
    } rsp_t;

endpackage

FILE: design/ffha_mul.sv
// ----------------------------------------------------------------------------
// ffha_mul: shift-add multiplier for calloc sizing
// 32 x 32 product, one multiplier bit per cycle; flags a result above 32 bits.
// ----------------------------------------------------------------------------
module ffha_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [31:0] product,
    output logic        overflow
);
    logic [63:0] acc_reg;
    logic [63:0] mcand_reg;
    logic [31:0] mplier_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;

    // Add one partial product per cycle, then shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            acc_reg    <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
        end
        else if (start)
        begin
            busy_reg   <= 1'b1;
            cnt_reg    <= '0;
            acc_reg    <= '0;
            mcand_reg  <= {32'd0, a};
            mplier_reg <= b;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
            cnt_reg    <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
                busy_reg <= 1'b0;
        end
    end

    assign done     = !busy_reg && (cnt_reg == 6'd32);
    assign product  = acc_reg[31:0];
    assign overflow = |acc_reg[63:32];
endmodule

FILE: design/first_fit_heap_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit: first-fit heap allocator with block table
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready as a req_t word; one rsp_t word leaves
// on out_valid/out_ready per request. The block takes one request at a time:
// in_ready is low from acceptance until the result word is taken, and rises
// again in the cycle after that handshake.
// The table is walked through the memory's single registered read port, each
// entry in an address state and then a compare state. An alloc that appends
// walks the whole table, a free or a first-fit hit stops at its entry, and a
// realloc that moves adds its lookup walk to the alloc walk. Calloc first runs
// the shift-add multiplier. The worst case at the default table of 64 entries
// is set by a realloc that moves.
// heap_limit is written through cfg_we/cfg_wdata whenever cfg_we is high.
// Reset empties the table and zeroes the break; heap_limit returns to 65536.
// Table contents need no clearing: only entries below the count are read.
// When out_ready is low the result word holds and no new request is taken.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ffha_pkg::req_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output ffha_pkg::rsp_t  out_data,
    input  logic            cfg_we,
    input  logic [31:0]     cfg_wdata
);
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [31:0] HDR = 32'(HEADER_BYTES);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_FIND, S_FIND_CHK, S_ALLOC, S_ALLOC_CHK,
        S_APPEND, S_DONE
    } state_t;

    // Table memory: one write and one registered read per cycle
    logic [31:0] mem_start [MAX_BLOCKS];
    logic [31:0] mem_size  [MAX_BLOCKS];
    logic        mem_free  [MAX_BLOCKS];
    logic [31:0] rd_start_reg, rd_size_reg;
    logic        rd_free_reg;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_start, wr_size;
    logic          wr_free;

    state_t        state_reg;
    logic [31:0]   limit_reg;
    logic [CW-1:0] count_reg;
    logic [31:0]   brk_reg;
    ffha_pkg::req_t req_reg;
    ffha_pkg::rsp_t rsp_reg;
    logic [31:0]   asize_reg;
    logic [CW-1:0] idx_reg;
    logic [IW-1:0] fidx_reg;
    logic [31:0]   fstart_reg, fsize_reg;
    logic          out_valid_reg;

    logic           acc_null;
    ffha_pkg::rsp_t rsp_init;
    ffha_pkg::rsp_t rsp_grant;

    logic        mul_start, mul_done, mul_ovf;
    logic [31:0] mul_prod;

    ffha_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_start),
        .a        (in_data.request_size),
        .b        (in_data.element_count),
        .done     (mul_done),
        .product  (mul_prod),
        .overflow (mul_ovf)
    );

    // Decide at acceptance whether the request is a null request
    always_comb
    begin
        acc_null = 1'b0;
        unique case (in_data.req_type)
            ffha_pkg::REQ_ALLOC:   acc_null = (in_data.request_size == 0);
            ffha_pkg::REQ_FREE:    acc_null = (in_data.user_address == 0);
            ffha_pkg::REQ_CALLOC:  acc_null = (in_data.request_size == 0)
                                              || (in_data.element_count == 0);
            ffha_pkg::REQ_REALLOC: acc_null = (in_data.request_size == 0);
        endcase
        rsp_init        = '0;
        rsp_init.status = acc_null ? ffha_pkg::ST_NULL : ffha_pkg::ST_OK;
    end

    // Result word for a granted block
    always_comb
    begin
        rsp_grant = rsp_reg;
        rsp_grant.result_address = (state_reg == S_APPEND) ? brk_reg + HDR
                                                           : rd_start_reg + HDR;
        if (req_reg.req_type == ffha_pkg::REQ_CALLOC)
            rsp_grant.clear_bytes = asize_reg;
        if (req_reg.req_type == ffha_pkg::REQ_REALLOC && req_reg.user_address != 0)
        begin
            rsp_grant.copy_source = req_reg.user_address;
            rsp_grant.copy_bytes  = fsize_reg;
        end
    end

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;
    assign mul_start = in_valid && in_ready && (in_data.req_type == ffha_pkg::REQ_CALLOC)
                       && !acc_null;
    assign rd_addr   = idx_reg[IW-1:0];

    logic [32:0] end_sum;
    assign end_sum = {1'b0, brk_reg} + {1'b0, HDR} + {1'b0, asize_reg};

    // Table memory port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_start[wr_addr] <= wr_start;
            mem_size[wr_addr]  <= wr_size;
            mem_free[wr_addr]  <= wr_free;
        end
        rd_start_reg <= mem_start[rd_addr];
        rd_size_reg  <= mem_size[rd_addr];
        rd_free_reg  <= mem_free[rd_addr];
    end

    // Table writes from the sequencer
    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = idx_reg[IW-1:0];
        wr_start = rd_start_reg;
        wr_size  = rd_size_reg;
        wr_free  = 1'b0;
        if (state_reg == S_ALLOC_CHK && rd_free_reg && rd_size_reg >= asize_reg)
            wr_en = 1'b1;
        else if (state_reg == S_APPEND && end_sum <= {1'b0, limit_reg} && count_reg < MAXC)
        begin
            wr_en    = 1'b1;
            wr_addr  = count_reg[IW-1:0];
            wr_start = brk_reg;
            wr_size  = asize_reg;
        end
        else if (state_reg == S_DONE && !out_valid_reg && rsp_reg.status == ffha_pkg::ST_OK
                 && (req_reg.req_type == ffha_pkg::REQ_FREE || rsp_reg.copy_source != 0)
                 && 32'(fidx_reg) + 32'd1 != 32'(count_reg))
        begin
            wr_en    = 1'b1;
            wr_addr  = fidx_reg;
            wr_start = fstart_reg;
            wr_size  = fsize_reg;
            wr_free  = 1'b1;
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= 32'd65536;
            count_reg     <= '0;
            brk_reg       <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            req_reg       <= '0;
            rsp_reg       <= '0;
            asize_reg     <= '0;
            fidx_reg      <= '0;
            fstart_reg    <= '0;
            fsize_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        req_reg   <= in_data;
                        rsp_reg   <= rsp_init;
                        idx_reg   <= '0;
                        asize_reg <= in_data.request_size;
                        priority if (acc_null)
                            state_reg <= S_DONE;
                        else if (in_data.req_type == ffha_pkg::REQ_CALLOC)
                            state_reg <= S_MUL;
                        else if (in_data.req_type == ffha_pkg::REQ_FREE
                                 || (in_data.req_type == ffha_pkg::REQ_REALLOC
                                     && in_data.user_address != 0))
                            state_reg <= S_FIND;
                        else
                            state_reg <= S_ALLOC;
                    end
                end
                S_MUL:
                begin
                    if (mul_done)
                    begin
                        if (mul_ovf)
                        begin
                            rsp_reg.status <= ffha_pkg::ST_OVF;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            asize_reg <= mul_prod;
                            state_reg <= S_ALLOC;
                        end
                    end
                end
                // Walk the table for the matching data offset
                S_FIND:
                begin
                    if (idx_reg >= count_reg)
                    begin
                        rsp_reg.status <= ffha_pkg::ST_UNKNOWN;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_FIND_CHK;
                end
                S_FIND_CHK:
                begin
                    if (rd_start_reg + HDR == req_reg.user_address)
                    begin
                        fidx_reg   <= idx_reg[IW-1:0];
                        fstart_reg <= rd_start_reg;
                        fsize_reg  <= rd_size_reg;
                        priority if (req_reg.req_type == ffha_pkg::REQ_FREE)
                            state_reg <= S_DONE;
                        else if (rd_size_reg >= req_reg.request_size)
                        begin
                            rsp_reg.result_address <= req_reg.user_address;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_ALLOC;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_FIND;
                    end
                end
                // First-fit walk
                S_ALLOC:
                begin
                    if (idx_reg >= count_reg)
                        state_reg <= S_APPEND;
                    else
                        state_reg <= S_ALLOC_CHK;
                end
                S_ALLOC_CHK:
                begin
                    if (rd_free_reg && rd_size_reg >= asize_reg)
                    begin
                        rsp_reg   <= rsp_grant;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_ALLOC;
                    end
                end
                S_APPEND:
                begin
                    state_reg <= S_DONE;
                    priority if (end_sum > {1'b0, limit_reg})
                        rsp_reg.status <= ffha_pkg::ST_OOM;
                    else if (count_reg >= MAXC)
                        rsp_reg.status <= ffha_pkg::ST_FULL;
                    else
                    begin
                        count_reg <= count_reg + CW'(1);
                        brk_reg   <= end_sum[31:0];
                        rsp_reg   <= rsp_grant;
                    end
                end
                // Release the old block if needed, then present the word
                S_DONE:
                begin
                    if (!out_valid_reg)
                    begin
                        if (rsp_reg.status == ffha_pkg::ST_OK
                            && (req_reg.req_type == ffha_pkg::REQ_FREE
                                || rsp_reg.copy_source != 0)
                            && 32'(fidx_reg) + 32'd1 == 32'(count_reg))
                        begin
                            brk_reg   <= fstart_reg;
                            count_reg <= count_reg - CW'(1);
                        end
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: dv/first_fit_heap_allocator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit_tb: self-checking bench for the heap allocator
// Runs a directed table of requests, fills the block table, then random request
// sequences under several heap limits. Every result word is checked against a
// local model of the block table, the break and the heap limit.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit_tb;

    localparam int TBL_DEPTH = 64;
    localparam int HDR = 16;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    ffha_pkg::req_t in_data;
    logic out_valid;
    logic out_ready;
    ffha_pkg::rsp_t out_data;
    logic cfg_we;
    logic [31:0] cfg_wdata;

    first_fit_heap_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Model state of the block table
    logic [31:0] blk_start [TBL_DEPTH];
    logic [31:0] blk_size [TBL_DEPTH];
    logic        blk_free [TBL_DEPTH];
    int          blk_count;
    logic [31:0] brk;
    logic [31:0] limit_reg;

    ffha_pkg::rsp_t pending_rsp[$];
    int   fail_cnt;
    int   rsp_cnt;
    int   req_cnt;
    int   stall_left;
    bit   idle_on;

    // Directed rows; chk marks rows whose result is typed in
    typedef struct {
        ffha_pkg::req_t r;
        bit             chk;
        ffha_pkg::rsp_t e;
    } dir_row_t;
    dir_row_t dir_rows[$];

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [2:0] grant_block(input logic [31:0] sz,
                                               output logic [31:0] addr);
        logic [32:0] stop;
        addr = '0;
        if (sz == 0)
            return ffha_pkg::ST_NULL;
        for (int i = 0; i < blk_count; i++)
        begin
            if (blk_free[i] && blk_size[i] >= sz)
            begin
                blk_free[i] = 1'b0;
                addr = blk_start[i] + HDR;
                return ffha_pkg::ST_OK;
            end
        end
        stop = {1'b0, brk} + 33'(HDR) + {1'b0, sz};
        if (stop > {1'b0, limit_reg})
            return ffha_pkg::ST_OOM;
        if (blk_count >= TBL_DEPTH)
            return ffha_pkg::ST_FULL;
        blk_start[blk_count] = brk;
        blk_size[blk_count] = sz;
        blk_free[blk_count] = 1'b0;
        blk_count++;
        addr = brk + HDR;
        brk = stop[31:0];
        return ffha_pkg::ST_OK;
    endfunction

    function automatic int lookup_block(input logic [31:0] addr);
        for (int i = 0; i < blk_count; i++)
            if (blk_start[i] + HDR == addr)
                return i;
        return -1;
    endfunction

    function automatic void release_block(input int i);
        if (i + 1 == blk_count)
        begin
            brk = blk_start[i];
            blk_count--;
        end
        else
            blk_free[i] = 1'b1;
    endfunction

    function automatic ffha_pkg::rsp_t predict_heap_op(input ffha_pkg::req_t r);
        ffha_pkg::rsp_t o;
        int idx;
        logic [63:0] prod;
        logic [31:0] oldsz;
        o = '0;
        case (r.req_type)
            ffha_pkg::REQ_ALLOC:
                o.status = grant_block(r.request_size, o.result_address);
            ffha_pkg::REQ_FREE:
            begin
                if (r.user_address == 0)
                    o.status = ffha_pkg::ST_NULL;
                else
                begin
                    idx = lookup_block(r.user_address);
                    if (idx < 0)
                        o.status = ffha_pkg::ST_UNKNOWN;
                    else
                        release_block(idx);
                end
            end
            ffha_pkg::REQ_CALLOC:
            begin
                prod = 64'(r.request_size) * 64'(r.element_count);
                if (r.request_size == 0 || r.element_count == 0)
                    o.status = ffha_pkg::ST_NULL;
                else if (prod > 64'hFFFF_FFFF)
                    o.status = ffha_pkg::ST_OVF;
                else
                begin
                    o.status = grant_block(prod[31:0], o.result_address);
                    if (o.status == ffha_pkg::ST_OK)
                        o.clear_bytes = prod[31:0];
                end
            end
            default:
            begin
                if (r.user_address == 0 || r.request_size == 0)
                    o.status = grant_block(r.request_size, o.result_address);
                else
                begin
                    idx = lookup_block(r.user_address);
                    if (idx < 0)
                        o.status = ffha_pkg::ST_UNKNOWN;
                    else if (blk_size[idx] >= r.request_size)
                        o.result_address = r.user_address;
                    else
                    begin
                        oldsz = blk_size[idx];
                        o.status = grant_block(r.request_size, o.result_address);
                        if (o.status == ffha_pkg::ST_OK)
                        begin
                            o.copy_source = r.user_address;
                            o.copy_bytes = oldsz;
                            release_block(idx);
                        end
                    end
                end
            end
        endcase
        return o;
    endfunction

    // Send one request word, idling a random burst first when enabled
    task automatic send_req(input ffha_pkg::req_t r, input bit chk,
                            input ffha_pkg::rsp_t e);
        ffha_pkg::rsp_t p;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        p = predict_heap_op(r);
        if (chk && p !== e)
        begin
            $display("%0t: directed row mismatch: expected %p actual %p", $time, e, p);
            fail_cnt++;
        end
        pending_rsp.push_back(p);
        req_cnt++;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (160) @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        limit_reg = v;
    endtask

    // Pick a size, mostly small, rarely huge
    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 0;
            2: return $urandom_range(1, 4096);
            default: return $urandom_range(1, 200);
        endcase
    endfunction

    // Pick an address: mostly a live block, sometimes junk
    function automatic logic [31:0] pick_addr();
        if (blk_count > 0 && $urandom_range(0, 9) < 8)
            return blk_start[$urandom_range(0, blk_count - 1)] + HDR;
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom;
    endfunction

    function automatic ffha_pkg::req_t random_req();
        ffha_pkg::req_t r;
        r.req_type = 2'($urandom_range(0, 3));
        if (blk_count > 40 && $urandom_range(0, 1) == 0)
            r.req_type = ffha_pkg::REQ_FREE;
        r.request_size = pick_size();
        r.element_count = ($urandom_range(0, 7) == 0) ? $urandom
                                                     : $urandom_range(0, 8);
        if (r.req_type == ffha_pkg::REQ_CALLOC && $urandom_range(0, 1) == 0)
            r.request_size = $urandom_range(0, 40);
        r.user_address = pick_addr();
        return r;
    endfunction

    function automatic dir_row_t mk(input logic [1:0] t, input logic [31:0] sz,
                                    input logic [31:0] cnt, input logic [31:0] ua,
                                    input bit chk, input logic [31:0] ra,
                                    input logic [2:0] st);
        dir_row_t d;
        d.r = '{req_type: t, request_size: sz, element_count: cnt, user_address: ua};
        d.chk = chk;
        d.e = '0;
        d.e.result_address = ra;
        d.e.status = st;
        return d;
    endfunction

    // Output side: stall bursts, compare against oldest expectation
    always @(posedge clk)
    begin
        ffha_pkg::rsp_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                rsp_cnt++;
                if (pending_rsp.size() == 0)
                begin
                    $display("%0t: result word with nothing expected: %p", $time, out_data);
                    fail_cnt++;
                end
                else
                begin
                    e = pending_rsp.pop_front();
                    if (out_data.result_address !== e.result_address)
                        $display("%0t: result_address expected %h actual %h",
                                 $time, e.result_address, out_data.result_address);
                    if (out_data.status !== e.status)
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.status, out_data.status);
                    if (out_data.copy_source !== e.copy_source)
                        $display("%0t: copy_source expected %h actual %h",
                                 $time, e.copy_source, out_data.copy_source);
                    if (out_data.copy_bytes !== e.copy_bytes)
                        $display("%0t: copy_bytes expected %h actual %h",
                                 $time, e.copy_bytes, out_data.copy_bytes);
                    if (out_data.clear_bytes !== e.clear_bytes)
                        $display("%0t: clear_bytes expected %h actual %h",
                                 $time, e.clear_bytes, out_data.clear_bytes);
                    if (out_data !== e)
                        fail_cnt++;
                end
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        ffha_pkg::rsp_t e;
        logic [31:0] limits [5];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        fail_cnt = 0;
        rsp_cnt = 0;
        req_cnt = 0;
        stall_left = 0;
        idle_on = 1'b1;
        blk_count = 0;
        brk = '0;
        limit_reg = 32'd65536;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset state, extremes, every error code but table full
        dir_rows.push_back(mk(ffha_pkg::REQ_ALLOC, 0, 0, 0, 1, 0, ffha_pkg::ST_NULL));
        dir_rows.push_back(mk(ffha_pkg::REQ_FREE, 5, 0, 0, 1, 0, ffha_pkg::ST_NULL));
        dir_rows.push_back(mk(ffha_pkg::REQ_FREE, 0, 0, 32'hFFFF_FFFF, 1, 0,
                              ffha_pkg::ST_UNKNOWN));
        dir_rows.push_back(mk(ffha_pkg::REQ_CALLOC, 0, 5, 0, 1, 0, ffha_pkg::ST_NULL));
        dir_rows.push_back(mk(ffha_pkg::REQ_CALLOC, 5, 0, 0, 1, 0, ffha_pkg::ST_NULL));
        dir_rows.push_back(mk(ffha_pkg::REQ_CALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, 0,
                              ffha_pkg::ST_OVF));
        dir_rows.push_back(mk(ffha_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 0, 0, 1, 0,
                              ffha_pkg::ST_OOM));
        dir_rows.push_back(mk(ffha_pkg::REQ_ALLOC, 100, 0, 0, 1, 16, ffha_pkg::ST_OK));
        dir_rows.push_back(mk(ffha_pkg::REQ_CALLOC, 4, 8, 0, 0, 0, ffha_pkg::ST_OK));
        dir_rows.push_back(mk(ffha_pkg::REQ_ALLOC, 50, 0, 0, 0, 0, ffha_pkg::ST_OK));
        dir_rows.push_back(mk(ffha_pkg::REQ_FREE, 0, 0, 16, 1, 0, ffha_pkg::ST_OK));
        dir_rows.push_back(mk(ffha_pkg::REQ_FREE, 0, 0, 16, 1, 0, ffha_pkg::ST_OK));
        dir_rows.push_back(mk(ffha_pkg::REQ_ALLOC, 60, 0, 0, 1, 16, ffha_pkg::ST_OK));
        dir_rows.push_back(mk(ffha_pkg::REQ_REALLOC, 80, 0, 16, 1, 16, ffha_pkg::ST_OK));
        dir_rows.push_back(mk(ffha_pkg::REQ_REALLOC, 300, 0, 16, 0, 0, ffha_pkg::ST_OK));
        dir_rows.push_back(mk(ffha_pkg::REQ_REALLOC, 20, 0, 0, 0, 0, ffha_pkg::ST_OK));
        dir_rows.push_back(mk(ffha_pkg::REQ_REALLOC, 0, 0, 16, 1, 0, ffha_pkg::ST_NULL));
        dir_rows.push_back(mk(ffha_pkg::REQ_REALLOC, 9, 0, 32'h1234_5677, 1, 0,
                              ffha_pkg::ST_UNKNOWN));
        dir_rows.push_back(mk(ffha_pkg::REQ_REALLOC, 32'hFFFF_FFFF, 0, 16, 1, 0,
                              ffha_pkg::ST_OOM));
        dir_rows.push_back(mk(ffha_pkg::REQ_CALLOC, 32'h0001_0000, 32'h0001_0000, 0, 1, 0,
                              ffha_pkg::ST_OVF));
        dir_rows.push_back(mk(ffha_pkg::REQ_CALLOC, 32'hFFFF_FFFF, 1, 0, 1, 0,
                              ffha_pkg::ST_OOM));
        foreach (dir_rows[i])
            send_req(dir_rows[i].r, dir_rows[i].chk, dir_rows[i].e);

        // Hold the sender until every result word is back
        wait_drain();

        // Fill the table with one-byte blocks to reach table full
        write_limit(32'hFFFF_FFFF);
        while (blk_count < TBL_DEPTH)
            send_req('{ffha_pkg::REQ_ALLOC, 32'd1, 32'd0, 32'd0}, 0, '0);
        e = '0;
        e.status = ffha_pkg::ST_FULL;
        send_req('{ffha_pkg::REQ_ALLOC, 32'd5000, 32'd0, 32'd0}, 1, e);
        while (blk_count > 0)
            send_req('{ffha_pkg::REQ_FREE, 32'd0, 32'd0, blk_start[blk_count - 1] + HDR},
                     0, '0);
        wait_drain();

        // Random phases under several heap limits, extremes among them
        limits[0] = 32'd0;
        limits[1] = 32'd2000;
        limits[2] = 32'd65536;
        limits[3] = 32'hFFFF_FFFF;
        limits[4] = 32'd600;
        for (int ph = 0; ph < 5; ph++)
        begin
            write_limit(limits[ph]);
            if (ph == 4)
                idle_on = 1'b0;
            for (int k = 0; k < 60; k++)
                send_req(random_req(), 0, '0);
            wait_drain();
        end

        $display("Covered %0d requests and %0d checked result words", req_cnt, rsp_cnt);
        $display("across directed error cases, a full table and five heap limits");
        if (fail_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: first_fit_heap_allocator_unit.f
design/ffha_pkg.sv
design/ffha_mul.sv
design/first_fit_heap_allocator_unit.sv
dv/first_fit_heap_allocator_unit_tb.sv
